// ----- rtl/dmvm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package dmvm_pkg;

  // Store geometry
  localparam int MAX_ROWS    = 16;
  localparam int MAX_COLS    = 16;
  localparam int MAX_RESULTS = 16;

  // Field widths of the words on the ports
  localparam int CFG_W       = 5;
  localparam int ROW_F_W     = 4;
  localparam int COL_F_W     = 4;
  localparam int VAL_W       = 32;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_PAD_W   = OUT_TDATA_W - ROW_F_W - VAL_W;

  // Internal widths
  localparam int ROW_AW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_AW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int MADDR_W = (MAX_ROWS * MAX_COLS > 1) ? $clog2(MAX_ROWS * MAX_COLS) : 1;
  localparam int FRAC_W  = 16;
  localparam int PROD_W  = 2 * VAL_W;
  localparam int TERM_W  = PROD_W - FRAC_W;
  localparam int ACC_W   = TERM_W + ((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1);

  // Largest usable counts; the register field caps the column count
  localparam int ROWS_LIM  = (MAX_ROWS < MAX_RESULTS) ? MAX_ROWS : MAX_RESULTS;
  localparam int COLS_CAP  = (1 << CFG_W) - 1;
  localparam int COLS_LIM  = (MAX_COLS < COLS_CAP) ? MAX_COLS : COLS_CAP;
  localparam int CFG_RESET = 16;

  // Register indexes
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  // Input word kinds
  localparam logic OP_MATRIX = 1'b0;
  localparam logic OP_VECTOR = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic              issue;
    logic              first_col;
    logic              last_col;
    logic              last_row;
    logic [ROW_AW-1:0] row;
    logic [COL_AW-1:0] col;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_busy;
    logic loaded;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- rtl/dense_matrix_vector_multiply.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Matrix and vector words load at one word per cycle while the block is idle.
// A start word starts the rows in turn; each row reads one column at a time through
// the single store read port, then runs through the multiply/accumulate pipeline,
// and waits on the result channel while an earlier result is still on offer.
// Reset (rst_n low, synchronous) clears control and sets both counts to 16;
// the matrix and vector stores are not cleared and hold nothing until written.

module dense_matrix_vector_multiply (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_tvalid,
  output logic                               in_tready,
  // [3:0] row_index, [7:4] col_index, [39:8] value
  input  wire [dmvm_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [0] opcode
  input  wire                                in_tuser,
  input  wire                                in_tlast,
  output logic                               out_tvalid,
  input  wire                                out_tready,
  // [3:0] result_row, [35:4] result_value, [39:36] zero
  output logic [dmvm_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // [0] saturated
  output logic                               out_tuser,
  output logic                               out_tlast,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire                                cfg_index,
  input  wire [dmvm_pkg::CFG_W-1:0]          cfg_data
);
  import dmvm_pkg::*;

  ctrl_cmd_t          cmd;
  dp_status_t         status;
  logic               in_fire;
  logic [ROW_F_W-1:0] res_row;
  logic [VAL_W-1:0]   res_value;

  assign in_fire = in_tvalid && in_tready;

  dmvm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready),
    .status    (status),
    .cmd       (cmd)
  );

  dmvm_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_opcode (in_tuser),
    .in_row    (in_tdata[ROW_F_W-1:0]),
    .in_col    (in_tdata[ROW_F_W+COL_F_W-1:ROW_F_W]),
    .in_value  (in_tdata[ROW_F_W+COL_F_W+VAL_W-1:ROW_F_W+COL_F_W]),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_row   (res_row),
    .out_value (res_value),
    .out_sat   (out_tuser),
    .out_last  (out_tlast)
  );

  assign out_tdata = {{OUT_PAD_W{1'b0}}, res_value, res_row};

endmodule

`default_nettype wire

// ----- rtl/dmvm_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dmvm_ctrl (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_tvalid,
  input  wire                      in_tuser,
  input  wire                      in_tlast,
  output logic                     in_tready,
  input  wire                      cfg_valid,
  input  wire                      cfg_index,
  input  wire [dmvm_pkg::CFG_W-1:0] cfg_data,
  output logic                     cfg_ready,
  input  dmvm_pkg::dp_status_t     status,
  output dmvm_pkg::ctrl_cmd_t      cmd
);
  import dmvm_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ARM  = 2'd1;
  localparam logic [1:0] S_RUN  = 2'd2;
  localparam logic [1:0] S_WAIT = 2'd3;

  localparam int RCMP_W = CFG_W + ROW_AW;
  localparam int CCMP_W = CFG_W + COL_AW;

  logic [1:0]        state_r, state_nxt;
  logic [ROW_AW-1:0] row_r, row_nxt;
  logic [COL_AW-1:0] col_r, col_nxt;
  logic [CFG_W-1:0]  rows_cfg_r, cols_cfg_r;
  logic [CFG_W-1:0]  n_rows, n_cols;
  logic              col_last, row_last, start_seen;

  // Configuration registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_cfg_r <= CFG_W'(CFG_RESET);
      cols_cfg_r <= CFG_W'(CFG_RESET);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ROWS: rows_cfg_r <= cfg_data;
        REG_COLS: cols_cfg_r <= cfg_data;
        default:  rows_cfg_r <= rows_cfg_r;
      endcase
    end
  end

  // Clamp counts to the usable range
  always_comb begin
    if (rows_cfg_r == '0)                    n_rows = CFG_W'(1);
    else if (rows_cfg_r > CFG_W'(ROWS_LIM))  n_rows = CFG_W'(ROWS_LIM);
    else                                     n_rows = rows_cfg_r;
    if (cols_cfg_r == '0)                    n_cols = CFG_W'(1);
    else if (cols_cfg_r > CFG_W'(COLS_LIM))  n_cols = CFG_W'(COLS_LIM);
    else                                     n_cols = cols_cfg_r;
  end

  assign col_last   = CCMP_W'(col_r) == CCMP_W'(n_cols - CFG_W'(1));
  assign row_last   = RCMP_W'(row_r) == RCMP_W'(n_rows - CFG_W'(1));
  assign in_tready  = (state_r == S_IDLE);
  assign start_seen = in_tvalid && in_tready && (in_tuser == OP_VECTOR) && in_tlast;

  // Sequence rows and columns
  always_comb begin
    state_nxt = state_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    unique case (state_r)
      S_IDLE: begin
        if (start_seen) begin
          state_nxt = S_ARM;
          row_nxt   = '0;
        end
      end
      S_ARM: begin
        if (!status.out_busy) begin
          state_nxt = S_RUN;
          col_nxt   = '0;
        end
      end
      S_RUN: begin
        if (col_last) state_nxt = S_WAIT;
        else          col_nxt   = col_r + COL_AW'(1);
      end
      S_WAIT: begin
        if (status.loaded) begin
          if (row_last) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_ARM;
            row_nxt   = row_r + ROW_AW'(1);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      row_r   <= '0;
      col_r   <= '0;
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
    end
  end

  // Drive the datapath
  always_comb begin
    cmd.issue     = (state_r == S_RUN);
    cmd.first_col = (col_r == '0);
    cmd.last_col  = col_last;
    cmd.last_row  = row_last;
    cmd.row       = row_r;
    cmd.col       = col_r;
  end

endmodule

`default_nettype wire

// ----- rtl/dmvm_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dmvm_datapath (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_fire,
  input  wire                         in_opcode,
  input  wire [dmvm_pkg::ROW_F_W-1:0] in_row,
  input  wire [dmvm_pkg::COL_F_W-1:0] in_col,
  input  wire [dmvm_pkg::VAL_W-1:0]   in_value,
  input  dmvm_pkg::ctrl_cmd_t         cmd,
  output dmvm_pkg::dp_status_t        status,
  output logic                        out_valid,
  input  wire                         out_ready,
  output logic [dmvm_pkg::ROW_F_W-1:0] out_row,
  output logic [dmvm_pkg::VAL_W-1:0]  out_value,
  output logic                        out_sat,
  output logic                        out_last
);
  import dmvm_pkg::*;

  logic [VAL_W-1:0]  mat_mem [MAX_ROWS*MAX_COLS];
  logic [VAL_W-1:0]  vec_mem [MAX_COLS];

  logic                    row_ok, col_ok, mat_we, vec_we;
  logic [MADDR_W-1:0]      mat_wa, mat_ra;
  logic [COL_AW-1:0]       vec_wa;
  logic [VAL_W-1:0]        m_rd_r, v_rd_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [TERM_W-1:0] term;
  logic signed [ACC_W-1:0]  acc_r;
  logic                    s1_v_r, s1_first_r, s1_last_r;
  logic                    s2_v_r, s2_first_r, s2_last_r;
  logic                    s3_v_r, s3_last_r;
  logic                    load, sat_hi, sat_lo;
  logic                    out_valid_r;
  logic [ROW_F_W-1:0]      out_row_r;
  logic [VAL_W-1:0]        out_value_r;
  logic                    out_sat_r, out_last_r;

  // Drop writes outside the store
  assign row_ok = 32'(in_row) < MAX_ROWS;
  assign col_ok = 32'(in_col) < MAX_COLS;
  assign mat_we = in_fire && (in_opcode == OP_MATRIX) && row_ok && col_ok;
  assign vec_we = in_fire && (in_opcode == OP_VECTOR) && col_ok;
  assign mat_wa = MADDR_W'(in_row) * MADDR_W'(MAX_COLS) + MADDR_W'(in_col);
  assign vec_wa = COL_AW'(in_col);
  assign mat_ra = MADDR_W'(cmd.row) * MADDR_W'(MAX_COLS) + MADDR_W'(cmd.col);

  // Matrix store, registered read
  always_ff @(posedge clk) begin
    if (mat_we) mat_mem[mat_wa] <= in_value;
    m_rd_r <= mat_mem[mat_ra];
  end

  // Vector store, registered read
  always_ff @(posedge clk) begin
    if (vec_we) vec_mem[vec_wa] <= in_value;
    v_rd_r <= vec_mem[cmd.col];
  end

  // Multiply, then floor each term to Q.16 and accumulate
  assign term = TERM_W'(prod_r >>> FRAC_W);

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'($signed(m_rd_r)) * PROD_W'($signed(v_rd_r));
    if (s2_v_r) begin
      if (s2_first_r) acc_r <= ACC_W'(term);
      else            acc_r <= acc_r + ACC_W'(term);
    end
  end

  // Advance the stage flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= cmd.issue;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_first_r <= cmd.first_col;
    s1_last_r  <= cmd.last_col;
    s2_first_r <= s1_first_r;
    s2_last_r  <= s1_last_r;
    s3_last_r  <= s2_last_r;
  end

  // Saturate the finished row sum to Q16.16
  assign load   = s3_v_r && s3_last_r;
  assign sat_hi = !acc_r[ACC_W-1] && (|acc_r[ACC_W-2:VAL_W-1]);
  assign sat_lo = acc_r[ACC_W-1] && !(&acc_r[ACC_W-2:VAL_W-1]);

  // Output register; hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_row_r  <= ROW_F_W'(cmd.row);
      out_last_r <= cmd.last_row;
      out_sat_r  <= sat_hi || sat_lo;
      priority if (sat_hi) out_value_r <= {1'b0, {(VAL_W-1){1'b1}}};
      else if (sat_lo)     out_value_r <= {1'b1, {(VAL_W-1){1'b0}}};
      else                 out_value_r <= acc_r[VAL_W-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_row   = out_row_r;
  assign out_value = out_value_r;
  assign out_sat   = out_sat_r;
  assign out_last  = out_last_r;

  always_comb begin
    status.out_busy = out_valid_r;
    status.loaded   = load;
  end

endmodule

`default_nettype wire

// ----- rtl/dmvm_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dmvm_checker (
  input wire                              clk,
  input wire                              rst_n,
  input wire                              in_tvalid,
  input wire                              in_tready,
  input wire                              in_tuser,
  input wire                              in_tlast,
  input wire                              out_tvalid,
  input wire                              out_tready,
  input wire [dmvm_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input wire                              out_tuser,
  input wire                              out_tlast
);
  import dmvm_pkg::*;

  // A result word waits until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  // No result right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result word present after reset");

  // A clipped sum shows one of the two limits
  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      (out_tdata[ROW_F_W+VAL_W-1:ROW_F_W] == 32'h7FFF_FFFF) ||
      (out_tdata[ROW_F_W+VAL_W-1:ROW_F_W] == 32'h8000_0000))
    else $error("saturated flag without a limit value");

  // Input stays closed while a result word other than the last is on offer
  a_busy_closed: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input open in the middle of a product");

  // A start word closes the input on the next cycle
  a_start_closes: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == OP_VECTOR) && in_tlast |=> !in_tready)
    else $error("input still open after a start word");

endmodule

bind dense_matrix_vector_multiply dmvm_checker u_dmvm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire
